/* hw/rtl/cdq_pkg.sv */
// shared types and codes for the circular deque
package cdq_pkg;

    typedef logic signed [31:0] data_t;

    // operation codes carried on func
    localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
    localparam logic [1:0] FN_PUSH_REAR  = 2'd1;
    localparam logic [1:0] FN_POP_FRONT  = 2'd2;
    localparam logic [1:0] FN_POP_REAR   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // per-cell update codes
    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_FROM_LEFT  = 2'd1;
    localparam logic [1:0] CELL_FROM_RIGHT = 2'd2;
    localparam logic [1:0] CELL_LOAD       = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        data_t      load_data;
    } cell_ctrl_t;

endpackage

/* hw/rtl/cdq_cell.sv */
// one storage cell of the deque chain, shifting toward either neighbor
module cdq_cell
    import cdq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  data_t      left_data,
    input  data_t      right_data,
    output data_t      data
);

    data_t data_reg;
    data_t data_next;

    always_comb
    begin
        case (ctrl.op)
            CELL_HOLD:       data_next = data_reg;
            CELL_FROM_LEFT:  data_next = left_data;
            CELL_FROM_RIGHT: data_next = right_data;
            CELL_LOAD:       data_next = ctrl.load_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* hw/rtl/circular_deque.sv */
// circular deque top level: control, fill count, cell chain and result register
//
// Double-ended queue of DEPTH signed 32-bit elements. Each transfer on the
// input channel (in_valid/in_ready, fields func and push_value) is one
// operation: push front, push rear, pop front or pop rear. Each produces
// exactly one result on the output channel (out_valid/out_ready, fields
// pop_value, status, is_empty, is_full).
// Elements live in a row of cells with the front element always in cell 0;
// a front push or pop shifts every cell one place toward its neighbor in the
// same cycle, a rear push loads the cell at the fill count, and a rear pop
// reads the cell just below it.
// The result is registered, valid in the cycle after the input transfer. One item
// per cycle is sustained while out_ready is high; the single result register sets it.
// When the receiver stalls, the result is held and in_ready drops until it
// is taken; an input arriving in the cycle the result leaves is accepted.
// Reset empties the deque (fill count zero) and drops out_valid; the result
// fields and cell contents are not cleared and are only read after being written.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  data_t       push_value,
    output logic        out_valid,
    input  logic        out_ready,
    output data_t       pop_value,
    output logic [1:0]  status,
    output logic        is_empty,
    output logic        is_full
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    data_t         pop_value_reg;
    logic [1:0]    status_reg;
    logic          is_empty_reg;
    logic          is_full_reg;

    data_t         pop_value_next;
    logic [1:0]    status_next;

    logic          in_fire;
    logic          is_push;
    logic          store_empty;
    logic          store_full;
    logic          push_ok;
    logic          pop_ok;
    data_t         rear_data;

    cell_ctrl_t    ctrl     [DEPTH];
    data_t         cell_data[DEPTH];

    assign in_fire     = in_valid && in_ready;
    assign in_ready    = !out_valid_reg || out_ready;
    assign is_push     = (func == FN_PUSH_FRONT) || (func == FN_PUSH_REAR);
    assign store_empty = (count_reg == '0);
    assign store_full  = (count_reg == FULL_COUNT);
    assign push_ok     = in_fire && is_push && !store_full;
    assign pop_ok      = in_fire && !is_push && !store_empty;

    // rear element: the cell whose index is one below the fill count
    always_comb
    begin
        rear_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (count_reg == CW'(i + 1))
            begin
                rear_data = rear_data | cell_data[i];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            data_t left_d;
            data_t right_d;

            if (g == 0)
            begin : g_first
                assign left_d = push_value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[g+1];
            end

            always_comb
            begin
                ctrl[g].op        = CELL_HOLD;
                ctrl[g].load_data = push_value;
                if (push_ok && (func == FN_PUSH_FRONT))
                begin
                    ctrl[g].op = CELL_FROM_LEFT;
                end
                else if (push_ok && (func == FN_PUSH_REAR) && (count_reg == CW'(g)))
                begin
                    ctrl[g].op = CELL_LOAD;
                end
                else if (pop_ok && (func == FN_POP_FRONT))
                begin
                    ctrl[g].op = CELL_FROM_RIGHT;
                end
            end

            cdq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[g]),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        pop_value_next = '0;
        status_next    = ST_DONE;
        if (is_push)
        begin
            if (store_full)
            begin
                status_next = ST_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (store_empty)
            begin
                status_next = ST_UNDERFLOW;
            end
            else
            begin
                count_next     = count_reg - CW'(1);
                pop_value_next = (func == FN_POP_FRONT) ? cell_data[0] : rear_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pop_value_reg <= pop_value_next;
            status_reg    <= status_next;
            is_empty_reg  <= (count_next == '0);
            is_full_reg   <= (count_next == FULL_COUNT);
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count beyond depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_OVERFLOW) |-> is_full_reg)
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_UNDERFLOW) |-> is_empty_reg)
        else $error("underflow reported while not empty");

    a_last_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !is_push && (count_reg == CW'(1)) |=> is_empty_reg && (count_reg == '0))
        else $error("popping the last element did not empty the deque");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted push did not grow the fill count");
`endif

endmodule
